@@ rtl/core/rvsc_pkg.sv @@
// Shared constants, codes and types of the RV32 subset core.
`timescale 1ns / 1ps

package rvsc_pkg;

    // Data path and register file geometry.
    localparam int XLEN         = 32;
    localparam int REG_COUNT    = 32;
    localparam int REG_IDX_BITS = 5;

    // Byte memory geometry: four byte-wide banks, one word row across them.
    localparam int MEM_ADDR_BITS = 16;
    localparam int BANK_COUNT    = 4;
    localparam int ROW_BITS      = MEM_ADDR_BITS - 2;
    localparam int MEM_ROWS      = 1 << ROW_BITS;

    // Result status codes.
    localparam logic [1:0] STATUS_LOADED      = 2'd0;
    localparam logic [1:0] STATUS_EXECUTED    = 2'd1;
    localparam logic [1:0] STATUS_UNSUPPORTED = 2'd2;

    // Major opcodes that the core executes.
    typedef enum logic [6:0] {
        OPC_LOAD   = 7'h03,
        OPC_OP_IMM = 7'h13,
        OPC_STORE  = 7'h23,
        OPC_OP     = 7'h33,
        OPC_JAL    = 7'h6f
    } opcode_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_EXEC,
        ST_LOAD
    } core_state_t;

    // Request to the byte memory: one word read or one word write per cycle.
    typedef struct packed {
        logic            rd_en;
        logic            wr_en;
        logic [XLEN-1:0] addr;
        logic [XLEN-1:0] wdata;
    } mem_req_t;

    // Request to the register file: two reads and one write.
    typedef struct packed {
        logic                    rd_en;
        logic [REG_IDX_BITS-1:0] rs1;
        logic [REG_IDX_BITS-1:0] rs2;
        logic                    wr_en;
        logic [REG_IDX_BITS-1:0] rd;
        logic [XLEN-1:0]         wdata;
    } rf_req_t;

    // Decoded and computed view of one instruction.
    typedef struct packed {
        logic                    supported;
        logic                    is_load;
        logic                    is_store;
        logic                    reg_write;
        logic [REG_IDX_BITS-1:0] reg_index;
        logic [XLEN-1:0]         reg_value;
        logic [XLEN-1:0]         load_address;
        logic [XLEN-1:0]         mem_address;
        logic [XLEN-1:0]         mem_value;
        logic [XLEN-1:0]         next_pc;
    } exec_res_t;

    // One result beat.
    typedef struct packed {
        logic [1:0]              status;
        logic [XLEN-1:0]         fetched_word;
        logic [XLEN-1:0]         next_pc;
        logic                    reg_write;
        logic [REG_IDX_BITS-1:0] reg_index;
        logic [XLEN-1:0]         reg_value;
        logic                    mem_write;
        logic [XLEN-1:0]         mem_address;
        logic [XLEN-1:0]         mem_value;
    } rsp_payload_t;

endpackage

@@ rtl/core/rvsc_cmd_if.sv @@
// Command channel: valid/ready handshake carrying one input beat.
`timescale 1ns / 1ps

interface rvsc_cmd_if;

    logic        valid;
    logic        ready;
    logic        mode;
    logic [15:0] load_address;
    logic [31:0] load_data;

    modport source (
        output valid,
        output mode,
        output load_address,
        output load_data,
        input  ready
    );

    modport sink (
        input  valid,
        input  mode,
        input  load_address,
        input  load_data,
        output ready
    );

endinterface

@@ rtl/core/rvsc_rsp_if.sv @@
// Response channel: valid/ready handshake carrying one result beat.
`timescale 1ns / 1ps

interface rvsc_rsp_if;

    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] fetched_word;
    logic [31:0] next_pc;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_write;
    logic [31:0] mem_address;
    logic [31:0] mem_value;

    modport source (
        output valid,
        output status,
        output fetched_word,
        output next_pc,
        output reg_write,
        output reg_index,
        output reg_value,
        output mem_write,
        output mem_address,
        output mem_value,
        input  ready
    );

    modport sink (
        input  valid,
        input  status,
        input  fetched_word,
        input  next_pc,
        input  reg_write,
        input  reg_index,
        input  reg_value,
        input  mem_write,
        input  mem_address,
        input  mem_value,
        output ready
    );

endinterface

@@ rtl/core/rvsc_mem.sv @@
// Byte memory built from four byte banks, with word access at any byte address.
`timescale 1ns / 1ps

module rvsc_mem (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rvsc_pkg::mem_req_t                req,
    output logic [rvsc_pkg::XLEN-1:0]         rdata,
    output logic                              clear_busy
);

    logic [rvsc_pkg::ROW_BITS:0]   clear_cnt_reg;
    logic [rvsc_pkg::ROW_BITS:0]   clear_cnt_next;
    logic [1:0]                    off;
    logic [rvsc_pkg::ROW_BITS-1:0] row_base;
    logic [1:0]                    off_reg;
    logic [7:0]                    bank_q [rvsc_pkg::BANK_COUNT];

    // Clearing sweep after reset: one row of all banks per cycle.
    assign clear_busy     = !clear_cnt_reg[rvsc_pkg::ROW_BITS];
    assign clear_cnt_next = clear_cnt_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
        end
        else if (clear_busy)
        begin
            clear_cnt_reg <= clear_cnt_next;
        end
    end

    // Byte offset inside a row and the row of the lowest byte.
    assign off      = req.addr[1:0];
    assign row_base = req.addr[rvsc_pkg::MEM_ADDR_BITS-1:2];

    // Remember the offset of the last read to rotate the bank outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg <= '0;
        end
        else if (req.rd_en)
        begin
            off_reg <= off;
        end
    end

    // Each bank holds the bytes whose address ends in its own number.
    for (genvar b = 0; b < rvsc_pkg::BANK_COUNT; b++)
    begin : g_bank
        logic [7:0]                    bank_mem [rvsc_pkg::MEM_ROWS];
        logic [1:0]                    byte_sel;
        logic [rvsc_pkg::ROW_BITS-1:0] row;
        logic [7:0]                    wbyte;
        logic [7:0]                    rbyte_reg;

        // Banks below the start offset hold bytes of the next row.
        assign byte_sel = 2'(b) - off;
        assign row      = row_base + rvsc_pkg::ROW_BITS'(2'(b) < off);
        assign wbyte    = req.wdata[{byte_sel, 3'b000} +: 8];

        always_ff @(posedge clk)
        begin
            if (clear_busy)
            begin
                bank_mem[clear_cnt_reg[rvsc_pkg::ROW_BITS-1:0]] <= '0;
            end
            else if (req.wr_en)
            begin
                bank_mem[row] <= wbyte;
            end
            if (req.rd_en)
            begin
                rbyte_reg <= bank_mem[row];
            end
        end

        assign bank_q[b] = rbyte_reg;
    end

    // Put the bank outputs back in little-endian byte order.
    always_comb
    begin
        logic [1:0] src;
        for (int j = 0; j < rvsc_pkg::BANK_COUNT; j++)
        begin
            src = 2'(j) + off_reg;
            rdata[8*j +: 8] = bank_q[src];
        end
    end

endmodule

@@ rtl/core/rvsc_regfile.sv @@
// Register file with two registered read ports, one write port and valid bits.
`timescale 1ns / 1ps

module rvsc_regfile (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rvsc_pkg::rf_req_t         req,
    output logic [rvsc_pkg::XLEN-1:0] rs1_val,
    output logic [rvsc_pkg::XLEN-1:0] rs2_val
);

    logic [rvsc_pkg::XLEN-1:0]      rf_mem [rvsc_pkg::REG_COUNT];
    logic [rvsc_pkg::REG_COUNT-1:0] valid_reg;
    logic [rvsc_pkg::XLEN-1:0]      rs1_q_reg;
    logic [rvsc_pkg::XLEN-1:0]      rs2_q_reg;
    logic                           rs1_ok_reg;
    logic                           rs2_ok_reg;

    // Entries never written since reset read as zero; x0 is never written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rs1_ok_reg <= 1'b0;
            rs2_ok_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.rd] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rs1_ok_reg <= valid_reg[req.rs1];
                rs2_ok_reg <= valid_reg[req.rs2];
            end
        end
    end

    // Storage array and registered read data.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            rf_mem[req.rd] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rs1_q_reg <= rf_mem[req.rs1];
            rs2_q_reg <= rf_mem[req.rs2];
        end
    end

    assign rs1_val = rs1_ok_reg ? rs1_q_reg : '0;
    assign rs2_val = rs2_ok_reg ? rs2_q_reg : '0;

endmodule

@@ rtl/core/rvsc_exec.sv @@
// Instruction decode, immediate generation and address/result arithmetic.
`timescale 1ns / 1ps

module rvsc_exec (
    input  logic [rvsc_pkg::XLEN-1:0] inst,
    input  logic [rvsc_pkg::XLEN-1:0] rs1_val,
    input  logic [rvsc_pkg::XLEN-1:0] rs2_val,
    input  logic [rvsc_pkg::XLEN-1:0] pc,
    output rvsc_pkg::exec_res_t       res
);

    logic [rvsc_pkg::REG_IDX_BITS-1:0] rd;
    logic [2:0]                        funct3;
    logic [rvsc_pkg::XLEN-1:0]         imm_i;
    logic [rvsc_pkg::XLEN-1:0]         imm_s;
    logic [rvsc_pkg::XLEN-1:0]         imm_j;
    logic [rvsc_pkg::XLEN-1:0]         imm_sh;
    logic [rvsc_pkg::XLEN-1:0]         addi_sum;
    logic [rvsc_pkg::XLEN-1:0]         add_sum;
    logic [rvsc_pkg::XLEN-1:0]         load_ea;
    logic [rvsc_pkg::XLEN-1:0]         store_ea;
    logic [rvsc_pkg::XLEN-1:0]         pc_plus4;
    logic [rvsc_pkg::XLEN-1:0]         jal_target;

    assign rd     = inst[11:7];
    assign funct3 = inst[14:12];

    // Immediates of the supported formats.
    assign imm_i  = {{20{inst[31]}}, inst[31:20]};
    assign imm_s  = {{20{inst[31]}}, inst[31:25], inst[11:7]};
    assign imm_j  = {{11{inst[31]}}, inst[31], inst[19:12], inst[20], inst[30:21], 1'b0};
    assign imm_sh = {27'd0, inst[24:20]};

    // Shift encodings of OP-IMM add the unsigned shift amount instead.
    always_comb
    begin
        if (funct3 inside {3'd1, 3'd5})
        begin
            addi_sum = rs1_val + imm_sh;
        end
        else
        begin
            addi_sum = rs1_val + imm_i;
        end
    end

    assign add_sum    = rs1_val + rs2_val;
    assign load_ea    = rs1_val + imm_i;
    assign store_ea   = rs1_val + imm_s;
    assign pc_plus4   = pc + 32'd4;
    assign jal_target = pc + imm_j;

    // Per-opcode result; anything else is unsupported and leaves pc alone.
    always_comb
    begin
        res           = '0;
        res.next_pc   = pc;
        case (rvsc_pkg::opcode_t'(inst[6:0]))
            rvsc_pkg::OPC_OP_IMM:
            begin
                res.supported = 1'b1;
                res.reg_write = (rd != '0);
                res.reg_value = addi_sum;
                res.next_pc   = pc_plus4;
            end
            rvsc_pkg::OPC_OP:
            begin
                res.supported = 1'b1;
                res.reg_write = (rd != '0);
                res.reg_value = add_sum;
                res.next_pc   = pc_plus4;
            end
            rvsc_pkg::OPC_JAL:
            begin
                res.supported = 1'b1;
                res.reg_write = (rd != '0);
                res.reg_value = pc_plus4;
                res.next_pc   = jal_target;
            end
            rvsc_pkg::OPC_LOAD:
            begin
                res.supported    = 1'b1;
                res.is_load      = 1'b1;
                res.reg_write    = (rd != '0);
                res.load_address = load_ea;
                res.next_pc      = pc_plus4;
            end
            rvsc_pkg::OPC_STORE:
            begin
                res.supported   = 1'b1;
                res.is_store    = 1'b1;
                res.mem_address = store_ea;
                res.mem_value   = rs2_val;
                res.next_pc     = pc_plus4;
            end
            default:
            begin
                res.supported = 1'b0;
            end
        endcase
        res.reg_index = res.reg_write ? rd : '0;
        if (!res.reg_write)
        begin
            res.reg_value = '0;
        end
    end

endmodule

@@ rtl/core/rv32_subset_core_step.sv @@
// Top level of the RV32 subset core: command buffer, sequencer and result register.
// A memory word write goes from the command buffer straight into the result register. An
// instruction is fetched, its source registers are read and it is executed; a word load then
// reads memory once more. The sequencer handles one instruction at a time through these steps,
// and the single command buffer can take the next beat once the sequencer has taken the last one.
// After reset the byte memory is swept to zero, with cmd.ready low throughout the sweep.
`timescale 1ns / 1ps

module rv32_subset_core_step (
    input  logic      clk,
    input  logic      rst_n,
    rvsc_cmd_if.sink   cmd,
    rvsc_rsp_if.source rsp
);

    rvsc_pkg::core_state_t     state_reg;
    rvsc_pkg::core_state_t     state_next;

    logic                      buf_valid_reg;
    logic                      buf_valid_next;
    logic                      buf_mode_reg;
    logic [15:0]               buf_addr_reg;
    logic [rvsc_pkg::XLEN-1:0] buf_data_reg;
    logic                      buf_take;
    logic                      cmd_fire;

    logic [rvsc_pkg::XLEN-1:0] pc_reg;
    logic [rvsc_pkg::XLEN-1:0] inst_reg;
    logic                      pc_update;
    logic                      inst_capture;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    rvsc_pkg::rsp_payload_t    out_payload_reg;
    rvsc_pkg::rsp_payload_t    res;
    logic                      out_free;
    logic                      push;

    rvsc_pkg::mem_req_t        mem_req;
    logic [rvsc_pkg::XLEN-1:0] mem_rdata;
    logic                      clear_busy;
    rvsc_pkg::rf_req_t         rf_req;
    logic [rvsc_pkg::XLEN-1:0] rs1_val;
    logic [rvsc_pkg::XLEN-1:0] rs2_val;
    rvsc_pkg::exec_res_t       ex;

    // Storage and execute units.
    rvsc_mem u_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (mem_req),
        .rdata      (mem_rdata),
        .clear_busy (clear_busy)
    );

    rvsc_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (rf_req),
        .rs1_val (rs1_val),
        .rs2_val (rs2_val)
    );

    rvsc_exec u_exec (
        .inst    (inst_reg),
        .rs1_val (rs1_val),
        .rs2_val (rs2_val),
        .pc      (pc_reg),
        .res     (ex)
    );

    // Command buffer: takes a beat whenever it is empty, outside the clear sweep.
    assign cmd.ready      = !buf_valid_reg && (state_reg != rvsc_pkg::ST_CLEAR);
    assign cmd_fire       = cmd.valid && cmd.ready;
    assign buf_valid_next = cmd_fire || (buf_valid_reg && !buf_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
        end
        else
        begin
            buf_valid_reg <= buf_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            buf_mode_reg <= cmd.mode;
            buf_addr_reg <= cmd.load_address;
            buf_data_reg <= cmd.load_data;
        end
    end

    // Result register: a new beat may enter while the old one leaves.
    assign out_free       = !out_valid_reg || rsp.ready;
    assign out_valid_next = push || (out_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_payload_reg <= res;
        end
        if (inst_capture)
        begin
            inst_reg <= mem_rdata;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_payload_reg.status;
    assign rsp.fetched_word = out_payload_reg.fetched_word;
    assign rsp.next_pc      = out_payload_reg.next_pc;
    assign rsp.reg_write    = out_payload_reg.reg_write;
    assign rsp.reg_index    = out_payload_reg.reg_index;
    assign rsp.reg_value    = out_payload_reg.reg_value;
    assign rsp.mem_write    = out_payload_reg.mem_write;
    assign rsp.mem_address  = out_payload_reg.mem_address;
    assign rsp.mem_value    = out_payload_reg.mem_value;

    // Program counter and sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rvsc_pkg::ST_CLEAR;
            pc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (pc_update)
            begin
                pc_reg <= ex.next_pc;
            end
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rvsc_pkg::ST_CLEAR:
            begin
                if (!clear_busy)
                begin
                    state_next = rvsc_pkg::ST_IDLE;
                end
            end
            rvsc_pkg::ST_IDLE:
            begin
                if (buf_valid_reg && buf_mode_reg)
                begin
                    state_next = rvsc_pkg::ST_DECODE;
                end
            end
            rvsc_pkg::ST_DECODE:
            begin
                state_next = rvsc_pkg::ST_EXEC;
            end
            rvsc_pkg::ST_EXEC:
            begin
                if (ex.is_load)
                begin
                    state_next = rvsc_pkg::ST_LOAD;
                end
                else if (out_free)
                begin
                    state_next = rvsc_pkg::ST_IDLE;
                end
            end
            rvsc_pkg::ST_LOAD:
            begin
                if (out_free)
                begin
                    state_next = rvsc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rvsc_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: memory and register file requests, result beat, commits.
    always_comb
    begin
        mem_req      = '0;
        rf_req       = '0;
        res          = '0;
        push         = 1'b0;
        buf_take     = 1'b0;
        pc_update    = 1'b0;
        inst_capture = 1'b0;

        // Fields of an executed instruction, used in the execute and load steps.
        res.status       = ex.supported ? rvsc_pkg::STATUS_EXECUTED
                                        : rvsc_pkg::STATUS_UNSUPPORTED;
        res.fetched_word = inst_reg;
        res.next_pc      = ex.next_pc;
        res.reg_write    = ex.reg_write;
        res.reg_index    = ex.reg_index;
        res.reg_value    = ex.reg_value;
        res.mem_write    = ex.is_store;
        res.mem_address  = ex.mem_address;
        res.mem_value    = ex.mem_value;

        case (state_reg)
            rvsc_pkg::ST_CLEAR:
            begin
                buf_take = 1'b0;
            end
            rvsc_pkg::ST_IDLE:
            begin
                if (buf_valid_reg && buf_mode_reg)
                begin
                    // Fetch the instruction word at pc.
                    mem_req.rd_en = 1'b1;
                    mem_req.addr  = pc_reg;
                    buf_take      = 1'b1;
                end
                else if (buf_valid_reg && out_free)
                begin
                    // Memory word write finishes in one step.
                    mem_req.wr_en = 1'b1;
                    mem_req.addr  = rvsc_pkg::XLEN'(buf_addr_reg);
                    mem_req.wdata = buf_data_reg;
                    buf_take      = 1'b1;
                    push          = 1'b1;
                    res           = '0;
                    res.status    = rvsc_pkg::STATUS_LOADED;
                    res.next_pc   = pc_reg;
                end
            end
            rvsc_pkg::ST_DECODE:
            begin
                // Instruction word is out of memory; read both source registers.
                inst_capture  = 1'b1;
                rf_req.rd_en  = 1'b1;
                rf_req.rs1    = mem_rdata[19:15];
                rf_req.rs2    = mem_rdata[24:20];
            end
            rvsc_pkg::ST_EXEC:
            begin
                if (ex.is_load)
                begin
                    mem_req.rd_en = 1'b1;
                    mem_req.addr  = ex.load_address;
                end
                else if (out_free)
                begin
                    push          = 1'b1;
                    pc_update     = 1'b1;
                    rf_req.wr_en  = ex.reg_write;
                    rf_req.rd     = ex.reg_index;
                    rf_req.wdata  = ex.reg_value;
                    mem_req.wr_en = ex.is_store;
                    mem_req.addr  = ex.mem_address;
                    mem_req.wdata = ex.mem_value;
                end
            end
            rvsc_pkg::ST_LOAD:
            begin
                // Load data sits in the memory read register until the beat leaves.
                res.reg_value = ex.reg_write ? mem_rdata : '0;
                if (out_free)
                begin
                    push         = 1'b1;
                    pc_update    = 1'b1;
                    rf_req.wr_en = ex.reg_write;
                    rf_req.rd    = ex.reg_index;
                    rf_req.wdata = mem_rdata;
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/core/rvsc_checker.sv @@
// Port-level checker for the RV32 subset core and its bind to the top level.
`timescale 1ns / 1ps

module rvsc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  status,
    input logic [31:0] fetched_word,
    input logic [31:0] next_pc,
    input logic        reg_write,
    input logic [4:0]  reg_index,
    input logic [31:0] reg_value,
    input logic        mem_write,
    input logic [31:0] mem_address,
    input logic [31:0] mem_value
);

    // A stalled result beat stays put.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(fetched_word)
            && $stable(next_pc) && $stable(reg_write) && $stable(reg_index)
            && $stable(reg_value) && $stable(mem_write) && $stable(mem_address)
            && $stable(mem_value))
        else $error("result beat changed while stalled");

    // Register write fields are zero without a write, and x0 is never reported.
    a_reg_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (reg_write ? (reg_index != 5'd0)
                                 : (reg_index == 5'd0 && reg_value == 32'd0)))
        else $error("register write fields inconsistent");

    // Store fields are zero without a store.
    a_mem_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !mem_write |-> mem_address == 32'd0 && mem_value == 32'd0)
        else $error("store fields set without a store");

    // Memory word writes and unsupported opcodes leave no architectural trace.
    a_no_effect: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != rvsc_pkg::STATUS_EXECUTED |-> !reg_write && !mem_write)
        else $error("side effect reported without an executed instruction");

    // A memory word write reports no fetched instruction.
    a_loaded_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == rvsc_pkg::STATUS_LOADED |-> fetched_word == 32'd0)
        else $error("fetched word reported for a memory word write");

endmodule

bind rv32_subset_core_step rvsc_checker u_rvsc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .status       (rsp.status),
    .fetched_word (rsp.fetched_word),
    .next_pc      (rsp.next_pc),
    .reg_write    (rsp.reg_write),
    .reg_index    (rsp.reg_index),
    .reg_value    (rsp.reg_value),
    .mem_write    (rsp.mem_write),
    .mem_address  (rsp.mem_address),
    .mem_value    (rsp.mem_value)
);

@@ verif/tb.sv @@
// Self-checking testbench for the RV32 subset core with a built-in predictor.
`timescale 1ns / 1ps

module tb;

    // Opcodes the core does not execute, used to provoke the unsupported status.
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    // funct3 values that matter for encoding.
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_WORD = 3'd2;
    localparam logic [2:0] F3_SRL  = 3'd5;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam int          MEM_SIZE     = 1 << rvsc_pkg::MEM_ADDR_BITS;
    localparam logic [31:0] MEM_MASK     = MEM_SIZE - 1;
    localparam int          DIR_ROWS     = 25;
    localparam int          RANDOM_ITEMS = 780;
    localparam int          HOLD_CYCLES  = 64;
    localparam int          CYCLE_LIMIT  = 250000;

    typedef struct packed {
        logic        mode;
        logic [15:0] load_address;
        logic [31:0] load_data;
    } cmd_beat_t;

    typedef struct packed {
        cmd_beat_t              beat;
        logic                   typed;
        rvsc_pkg::rsp_payload_t want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    rvsc_cmd_if cmd_ch ();
    rvsc_rsp_if rsp_ch ();

    rv32_subset_core_step DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // Architectural state mirrored by the predictor.
    logic [31:0] arch_x [0:31];
    logic [31:0] arch_pc;
    logic [7:0]  arch_mem [0:MEM_SIZE-1];

    rvsc_pkg::rsp_payload_t pending_rsp [$];

    int errors        = 0;
    int results_seen  = 0;
    int items_sent    = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Clock, period 4 ns.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Little-endian word read from the mirrored byte memory, wrapping at the top.
    function automatic logic [31:0] mem_word(input logic [31:0] addr);
        logic [31:0] w;
        w = '0;
        for (int i = 3; i >= 0; i--)
        begin
            w = {w[23:0], arch_mem[(addr + i) & MEM_MASK]};
        end
        return w;
    endfunction

    task automatic mem_store(input logic [31:0] addr, input logic [31:0] w);
        for (int i = 0; i < 4; i++)
        begin
            arch_mem[(addr + i) & MEM_MASK] = w[8*i +: 8];
        end
    endtask

    // Predict the result of one beat and advance the mirrored state.
    task automatic core_step(input cmd_beat_t c, output rvsc_pkg::rsp_payload_t r);
        logic [31:0] inst;
        logic [31:0] imm;
        logic [31:0] val;
        logic [31:0] pc;
        logic [6:0]  op;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [2:0]  f3;
        bit          wr;
        r    = '0;
        inst = '0;
        val  = '0;
        wr   = 1'b0;
        pc   = arch_pc;
        if (c.mode == 1'b0)
        begin
            mem_store({16'h0, c.load_address}, c.load_data);
            r.status = rvsc_pkg::STATUS_LOADED;
        end
        else
        begin
            inst = mem_word(pc);
            op   = inst[6:0];
            rd   = inst[11:7];
            f3   = inst[14:12];
            rs1  = inst[19:15];
            rs2  = inst[24:20];
            r.status = rvsc_pkg::STATUS_EXECUTED;
            case (op)
                rvsc_pkg::OPC_OP_IMM:
                begin
                    // Shift encodings add the unsigned shamt instead.
                    if (f3 == F3_SLL || f3 == F3_SRL)
                        imm = {27'h0, rs2};
                    else
                        imm = {{20{inst[31]}}, inst[31:20]};
                    val = arch_x[rs1] + imm;
                    wr  = 1'b1;
                    pc  = pc + 32'd4;
                end
                rvsc_pkg::OPC_OP:
                begin
                    val = arch_x[rs1] + arch_x[rs2];
                    wr  = 1'b1;
                    pc  = pc + 32'd4;
                end
                rvsc_pkg::OPC_JAL:
                begin
                    imm = {{11{inst[31]}}, inst[31], inst[19:12], inst[20], inst[30:21], 1'b0};
                    val = pc + 32'd4;
                    wr  = 1'b1;
                    pc  = pc + imm;
                end
                rvsc_pkg::OPC_LOAD:
                begin
                    imm = {{20{inst[31]}}, inst[31:20]};
                    val = mem_word(arch_x[rs1] + imm);
                    wr  = 1'b1;
                    pc  = pc + 32'd4;
                end
                rvsc_pkg::OPC_STORE:
                begin
                    imm = {{20{inst[31]}}, inst[31:25], inst[11:7]};
                    r.mem_write   = 1'b1;
                    r.mem_address = arch_x[rs1] + imm;
                    r.mem_value   = arch_x[rs2];
                    mem_store(r.mem_address, r.mem_value);
                    pc = pc + 32'd4;
                end
                default:
                begin
                    r.status = rvsc_pkg::STATUS_UNSUPPORTED;
                end
            endcase
            // Writes to x0 are dropped.
            if (wr && rd != 5'd0)
            begin
                arch_x[rd]  = val;
                r.reg_write = 1'b1;
                r.reg_index = rd;
                r.reg_value = val;
            end
            arch_pc = pc;
        end
        r.fetched_word = inst;
        r.next_pc      = arch_pc;
    endtask

    // Instruction encoders.
    function automatic logic [31:0] enc_i(input logic [6:0] op, input logic [4:0] rd,
                                          input logic [2:0] f3, input logic [4:0] rs1,
                                          input logic [11:0] imm);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3,
                                          input logic [4:0] rd);
        return {f7, rs2, rs1, f3, rd, rvsc_pkg::OPC_OP};
    endfunction

    function automatic logic [31:0] enc_s(input logic [4:0] rs2, input logic [4:0] rs1,
                                          input logic [11:0] imm);
        return {imm[11:5], rs2, rs1, F3_WORD, imm[4:0], rvsc_pkg::OPC_STORE};
    endfunction

    function automatic logic [31:0] enc_j(input logic [4:0] rd, input logic [20:0] imm);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, rvsc_pkg::OPC_JAL};
    endfunction

    function automatic cmd_beat_t mk_beat(input logic m, input logic [15:0] a,
                                          input logic [31:0] d);
        cmd_beat_t b;
        b.mode         = m;
        b.load_address = a;
        b.load_data    = d;
        return b;
    endfunction

    function automatic dir_row_t plain_row(input logic m, input logic [15:0] a,
                                           input logic [31:0] d);
        dir_row_t r;
        r.beat  = mk_beat(m, a, d);
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    // Row whose result is written out by hand; no store fields are ever set here.
    function automatic dir_row_t typed_row(input logic m, input logic [15:0] a,
                                           input logic [31:0] d, input logic [1:0] st,
                                           input logic [31:0] fw, input logic [31:0] npc,
                                           input logic rw, input logic [4:0] ri,
                                           input logic [31:0] rv);
        dir_row_t r;
        r.beat              = mk_beat(m, a, d);
        r.typed             = 1'b1;
        r.want              = '0;
        r.want.status       = st;
        r.want.fetched_word = fw;
        r.want.next_pc      = npc;
        r.want.reg_write    = rw;
        r.want.reg_index    = ri;
        r.want.reg_value    = rv;
        return r;
    endfunction

    function automatic logic [6:0] odd_opcode();
        case ($urandom_range(5))
            0:       return OPC_BRANCH;
            1:       return OPC_JALR;
            2:       return OPC_LUI;
            3:       return OPC_AUIPC;
            4:       return OPC_SYSTEM;
            default: return 7'($urandom());
        endcase
    endfunction

    // Random instruction with random fields; loads and stores often use x0 as base
    // so that they land near address zero, where code and data collide.
    function automatic logic [31:0] random_instr();
        logic [31:0] w;
        int          pick;
        w    = $urandom();
        pick = $urandom_range(99);
        if (pick < 25)
            w[6:0] = rvsc_pkg::OPC_OP_IMM;
        else if (pick < 43)
            w[6:0] = rvsc_pkg::OPC_OP;
        else if (pick < 58)
        begin
            w[6:0] = rvsc_pkg::OPC_LOAD;
            if ($urandom_range(1) == 1)
                w[19:15] = 5'd0;
        end
        else if (pick < 73)
        begin
            w[6:0] = rvsc_pkg::OPC_STORE;
            if ($urandom_range(1) == 1)
                w[19:15] = 5'd0;
        end
        else if (pick < 85)
            w[6:0] = rvsc_pkg::OPC_JAL;
        else
            w[6:0] = odd_opcode();
        return w;
    endfunction

    // Compare one result field; every mismatch prints one line and counts.
    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
        begin
            errors++;
            $display("mismatch on result %0d: %s got %h want %h",
                     results_seen, what, got, want);
        end
    endtask

    // Offer one command beat, predict it once it is taken.
    task automatic send_beat(input cmd_beat_t b, input logic typed,
                             input rvsc_pkg::rsp_payload_t want);
        rvsc_pkg::rsp_payload_t pred;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.mode         <= b.mode;
        cmd_ch.load_address <= b.load_address;
        cmd_ch.load_data    <= b.load_data;
        @(posedge clk);
        while (cmd_ch.ready !== 1'b1)
            @(posedge clk);
        core_step(b, pred);
        pending_rsp.push_back(typed ? want : pred);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_random(input cmd_beat_t b);
        send_beat(b, 1'b0, '0);
    endtask

    // One random sequence: mostly short programs written at pc and then run.
    task automatic run_sequence();
        logic [15:0] base;
        int          n;
        int          kind;
        kind = $urandom_range(99);
        base = arch_pc[15:0];
        if (kind < 75)
        begin
            n = $urandom_range(4, 1);
            for (int k = 0; k < n; k++)
                send_random(mk_beat(1'b0, base + 16'(4 * k), random_instr()));
            for (int k = 0; k < n; k++)
                send_random(mk_beat(1'b1, 16'($urandom()), $urandom()));
        end
        else if (kind < 85)
        begin
            // Broken: the word lands beside pc, not at it.
            send_random(mk_beat(1'b0, base + 16'($urandom_range(3, 1)), random_instr()));
            send_random(mk_beat(1'b1, 16'($urandom()), $urandom()));
        end
        else if (kind < 93)
            send_random(mk_beat(1'b0, 16'($urandom()), $urandom()));
        else
            send_random(mk_beat(1'b1, 16'($urandom()), $urandom()));
    endtask

    // Stimulus: reset, directed table, three random phases, drain.
    initial
    begin : stimulus
        dir_row_t dir_rows [0:DIR_ROWS-1];
        int       target;
        for (int i = 0; i < 32; i++)
            arch_x[i] = '0;
        for (int i = 0; i < MEM_SIZE; i++)
            arch_mem[i] = '0;
        arch_pc             = '0;
        rst_n               = 1'b0;
        cmd_ch.valid        = 1'b0;
        cmd_ch.mode         = 1'b0;
        cmd_ch.load_address = '0;
        cmd_ch.load_data    = '0;
        send_idle_pct       = 31;
        recv_idle_pct       = 76;

        dir_rows = '{
            // Fetch from cleared memory right after reset.
            typed_row(1'b1, 16'h0000, 32'h0, rvsc_pkg::STATUS_UNSUPPORTED, 32'h0, 32'h0,
                      1'b0, 5'd0, 32'h0),
            typed_row(1'b0, 16'h0000,
                      enc_i(rvsc_pkg::OPC_OP_IMM, 5'd1, F3_ADD, 5'd0, 12'hFFF),
                      rvsc_pkg::STATUS_LOADED, 32'h0, 32'h0, 1'b0, 5'd0, 32'h0),
            typed_row(1'b1, 16'h0000, 32'h0, rvsc_pkg::STATUS_EXECUTED,
                      enc_i(rvsc_pkg::OPC_OP_IMM, 5'd1, F3_ADD, 5'd0, 12'hFFF), 32'h4,
                      1'b1, 5'd1, 32'hFFFF_FFFF),
            typed_row(1'b0, 16'h0004,
                      enc_i(rvsc_pkg::OPC_OP_IMM, 5'd2, F3_ADD, 5'd0, 12'h7FF),
                      rvsc_pkg::STATUS_LOADED, 32'h0, 32'h4, 1'b0, 5'd0, 32'h0),
            typed_row(1'b1, 16'hFFFF, 32'hFFFF_FFFF, rvsc_pkg::STATUS_EXECUTED,
                      enc_i(rvsc_pkg::OPC_OP_IMM, 5'd2, F3_ADD, 5'd0, 12'h7FF), 32'h8,
                      1'b1, 5'd2, 32'h0000_07FF),
            // Shift encoding adds shamt.
            plain_row(1'b0, 16'h0008,
                      enc_i(rvsc_pkg::OPC_OP_IMM, 5'd3, F3_SLL, 5'd1, 12'h01F)),
            plain_row(1'b1, 16'h0000, 32'h0),
            // Add into x0 with junk funct fields.
            plain_row(1'b0, 16'h000C, enc_r(7'h7F, 5'd2, 5'd1, F3_AND, 5'd0)),
            plain_row(1'b1, 16'h0000, 32'h0),
            // Store to a negative address that wraps to the top of memory.
            plain_row(1'b0, 16'h0010, enc_s(5'd2, 5'd0, 12'hFFC)),
            plain_row(1'b1, 16'h0000, 32'h0),
            // Load a word that crosses the top of memory.
            plain_row(1'b0, 16'h0014,
                      enc_i(rvsc_pkg::OPC_LOAD, 5'd4, F3_WORD, 5'd0, 12'hFFE)),
            plain_row(1'b1, 16'h0000, 32'h0),
            // Most negative jump, pc wraps below zero.
            plain_row(1'b0, 16'h0018, enc_j(5'd5, 21'h10_0000)),
            plain_row(1'b1, 16'h0000, 32'h0),
            // Most positive jump into x0, lands on a halfword-aligned pc.
            plain_row(1'b0, 16'h0018, enc_j(5'd0, 21'h0F_FFFE)),
            plain_row(1'b1, 16'h0000, 32'h0),
            plain_row(1'b0, 16'hFFFF, 32'hFFFF_FFFF),
            plain_row(1'b0, 16'h8000, 32'h0),
            // Branches and unknown opcodes hold pc.
            plain_row(1'b0, 16'h0016, {25'h0, OPC_BRANCH}),
            typed_row(1'b1, 16'h0000, 32'h0, rvsc_pkg::STATUS_UNSUPPORTED,
                      {25'h0, OPC_BRANCH}, 32'h16, 1'b0, 5'd0, 32'h0),
            plain_row(1'b0, 16'h0016, 32'hFFFF_FFFF),
            typed_row(1'b1, 16'h0000, 32'h0, rvsc_pkg::STATUS_UNSUPPORTED, 32'hFFFF_FFFF,
                      32'h16, 1'b0, 5'd0, 32'h0),
            plain_row(1'b0, 16'h0016,
                      enc_i(rvsc_pkg::OPC_OP_IMM, 5'd6, F3_SRL, 5'd2, 12'h41F)),
            plain_row(1'b1, 16'h0000, 32'h0)
        };

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);

        // Random phases: sender idles less, then more, then neither side idles.
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 76 : 0;
            recv_idle_pct = (ph == 0) ? 76 : (ph == 1) ? 31 : 0;
            target        = DIR_ROWS + (ph + 1) * RANDOM_ITEMS / 3;
            while (items_sent < target)
                run_sequence();
        end
        cmd_ch.valid <= 1'b0;

        // Drain, then allow a few cycles for stray beats.
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Result sink: random ready, with a long hold every so often so the core backs up.
    initial
    begin : result_sink
        int next_hold_at;
        next_hold_at = 150;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (results_seen >= next_hold_at)
            begin
                next_hold_at = next_hold_at + 500;
                rsp_ch.ready <= 1'b0;
                for (int hold = 0; hold < HOLD_CYCLES; hold++)
                    @(negedge clk);
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result checker: each beat against the oldest expectation.
    always @(posedge clk)
    begin : check_rsp
        rvsc_pkg::rsp_payload_t want;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            results_seen <= results_seen + 1;
            if (pending_rsp.size() == 0)
            begin
                check_field("unexpected beat, status", {30'h0, rsp_ch.status}, 32'hx);
            end
            else
            begin
                want = pending_rsp.pop_front();
                check_field("status", {30'h0, rsp_ch.status}, {30'h0, want.status});
                check_field("fetched_word", rsp_ch.fetched_word, want.fetched_word);
                check_field("next_pc", rsp_ch.next_pc, want.next_pc);
                check_field("reg_write", {31'h0, rsp_ch.reg_write}, {31'h0, want.reg_write});
                check_field("reg_index", {27'h0, rsp_ch.reg_index}, {27'h0, want.reg_index});
                check_field("reg_value", rsp_ch.reg_value, want.reg_value);
                check_field("mem_write", {31'h0, rsp_ch.mem_write}, {31'h0, want.mem_write});
                check_field("mem_address", rsp_ch.mem_address, want.mem_address);
                check_field("mem_value", rsp_ch.mem_value, want.mem_value);
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats still expected",
                     cycle_count, pending_rsp.size());
            $display("status: fail");
            $finish;
        end
    end

endmodule
